// ===== hw/rtl/lis_pkg.sv =====
// Package for the longest increasing subsequence unit.
// Holds the sequencer state type, the configuration codes and the fixed field widths.
// Used by the channel interfaces and by every module of the block.
package lis_pkg;

    localparam int LEN_BITS      = 7;
    localparam int SLOT_BITS     = 6;
    localparam int TAIL_BITS     = 32;
    localparam int POS_BITS      = 32;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STRICT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EMIT   = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_lis_state;

    typedef struct packed {
        logic strict_increase;
        logic emit_tails;
    } t_lis_cfg;

endpackage

// ===== hw/rtl/lis_if.sv =====
// Channel interfaces of the longest increasing subsequence unit.
// Input words, result words and configuration writes; depends on lis_pkg.
interface lis_in_if import lis_pkg::*; #(
    parameter int VALUE_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface lis_out_if import lis_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LEN_BITS-1:0]  lis_length;
    logic [SLOT_BITS-1:0] slot;
    logic [TAIL_BITS-1:0] tail_value;
    logic [POS_BITS-1:0]  tail_position;
    logic                 overflow;
    logic                 end_of_run;

    modport source (output valid, lis_length, slot, tail_value, tail_position, overflow,
                    end_of_run, input ready);
    modport sink   (input valid, lis_length, slot, tail_value, tail_position, overflow,
                    end_of_run, output ready);
endinterface

interface lis_cfg_if import lis_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lis_tails_mem.sv =====
// Tails table storage: values and sequence positions, one write and one read port.
// Read data is registered. Depends on lis_pkg.
module lis_tails_mem import lis_pkg::*; #(
    parameter int MAX_TAILS  = 64,
    parameter int VALUE_BITS = 32,
    localparam int AW = (MAX_TAILS > 1) ? $clog2(MAX_TAILS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [VALUE_BITS-1:0] i_wvalue,
    input  logic [POS_BITS-1:0]   i_wpos,
    input  logic [AW-1:0]         i_raddr,
    output logic [VALUE_BITS-1:0] o_rvalue,
    output logic [POS_BITS-1:0]   o_rpos
);

    logic [VALUE_BITS-1:0] r_values [MAX_TAILS];
    logic [POS_BITS-1:0]   r_positions [MAX_TAILS];
    logic [VALUE_BITS-1:0] r_rvalue;
    logic [POS_BITS-1:0]   r_rpos;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_values[i_waddr]    <= i_wvalue;
            r_positions[i_waddr] <= i_wpos;
        end
        r_rvalue <= r_values[i_raddr];
        r_rpos   <= r_positions[i_raddr];
    end

    assign o_rvalue = r_rvalue;
    assign o_rpos   = r_rpos;

endmodule

// ===== hw/rtl/lis_seq.sv =====
// Sequencer of the unit: binary search over the tails table with one shared comparator,
// table update, result register and the tails run. Depends on lis_pkg and lis_if.
module lis_seq import lis_pkg::*; #(
    parameter int MAX_TAILS  = 64,
    parameter int VALUE_BITS = 32,
    localparam int AW = (MAX_TAILS > 1) ? $clog2(MAX_TAILS) : 1,
    localparam int LW = $clog2(MAX_TAILS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lis_cfg              i_cfg,
    lis_in_if.sink                i_in,
    lis_out_if.source             o_out,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output logic [VALUE_BITS-1:0] o_mem_wvalue,
    output logic [POS_BITS-1:0]   o_mem_wpos,
    output logic [AW-1:0]         o_mem_raddr,
    input  logic [VALUE_BITS-1:0] i_mem_rvalue,
    input  logic [POS_BITS-1:0]   i_mem_rpos
);

    t_lis_state r_state, n_state;
    logic [LW-1:0]         r_len, n_len;
    logic [POS_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_ovf, n_ovf;
    logic [LW-1:0]         r_lo, n_lo;
    logic [LW-1:0]         r_hi, n_hi;
    logic [AW-1:0]         r_mid, n_mid;
    logic [AW-1:0]         r_idx, n_idx;
    logic [VALUE_BITS-1:0] r_key, n_key;
    logic                  r_last, n_last;
    logic [POS_BITS-1:0]   r_pos, n_pos;

    logic                  r_ov, n_ov;
    logic [LEN_BITS-1:0]   r_o_len, n_o_len;
    logic [SLOT_BITS-1:0]  r_o_slot, n_o_slot;
    logic [TAIL_BITS-1:0]  r_o_value, n_o_value;
    logic [POS_BITS-1:0]   r_o_pos, n_o_pos;
    logic                  r_o_ovf, n_o_ovf;
    logic                  r_o_eor, n_o_eor;

    logic          accept;
    logic          out_free;
    logic          emit_mode;
    logic          s_hit;
    logic [LW-1:0] s_lo, s_hi;
    logic [LW:0]   s_sum;
    logic [AW-1:0] s_mid;
    logic          f_append, f_full, f_drop, f_go;
    logic [LW-1:0] f_len;
    logic          f_ovf;
    logic          ld_fin, ld_emit, emit_end;

    assign accept    = i_in.valid && i_in.ready;
    assign out_free  = !r_ov || o_out.ready;
    assign emit_mode = r_last && i_cfg.emit_tails;

    // One probe per cycle: the comparison of the returned tail picks the next half.
    assign s_hit = i_cfg.strict_increase ? ($signed(i_mem_rvalue) >= $signed(r_key))
                                         : ($signed(i_mem_rvalue) > $signed(r_key));
    assign s_lo  = s_hit ? r_lo : LW'(r_mid) + LW'(1);
    assign s_hi  = s_hit ? LW'(r_mid) : r_hi;
    assign s_sum = {1'b0, s_lo} + {1'b0, s_hi};
    assign s_mid = AW'(s_sum >> 1);

    assign f_append = (r_lo == r_len);
    assign f_full   = (r_len == LW'(MAX_TAILS));
    assign f_drop   = f_append && f_full;
    assign f_len    = (f_append && !f_full) ? r_len + LW'(1) : r_len;
    assign f_ovf    = r_ovf || f_drop;
    assign f_go     = (r_state == ST_FINISH) && (emit_mode || out_free);
    assign ld_fin   = f_go && !emit_mode;
    assign emit_end = (LW'(r_idx) + LW'(1)) == r_len;
    assign ld_emit  = (r_state == ST_EMIT_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (r_len == '0) ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (s_lo == s_hi) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (emit_mode) begin
                    n_state = ST_EMIT_RD;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    n_state = emit_end ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready   = (r_state == ST_IDLE);
        o_mem_we     = f_go && !f_drop;
        o_mem_waddr  = AW'(r_lo);
        o_mem_wvalue = r_key;
        o_mem_wpos   = r_pos;
        case (r_state)
            ST_IDLE:   o_mem_raddr = AW'(r_len >> 1);
            ST_SEARCH: o_mem_raddr = s_mid;
            default:   o_mem_raddr = r_idx;
        endcase
    end

    always_comb begin
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_idx     = r_idx;
        n_key     = r_key;
        n_last    = r_last;
        n_pos     = r_pos;
        n_ov      = r_ov && !o_out.ready;
        n_o_len   = r_o_len;
        n_o_slot  = r_o_slot;
        n_o_value = r_o_value;
        n_o_pos   = r_o_pos;
        n_o_ovf   = r_o_ovf;
        n_o_eor   = r_o_eor;

        if (accept) begin
            n_lo   = '0;
            n_hi   = r_len;
            n_mid  = AW'(r_len >> 1);
            n_idx  = '0;
            n_key  = i_in.value;
            n_last = i_in.last;
            n_pos  = r_cnt;
            n_cnt  = (r_cnt == '1) ? r_cnt : r_cnt + POS_BITS'(1);
        end

        if (r_state == ST_SEARCH) begin
            n_lo  = s_lo;
            n_hi  = s_hi;
            n_mid = s_mid;
        end

        if (f_go) begin
            n_len = f_len;
            n_ovf = f_ovf;
        end

        if (ld_fin) begin
            n_ov      = 1'b1;
            n_o_len   = LEN_BITS'(f_len);
            n_o_slot  = f_drop ? '0 : SLOT_BITS'(r_lo);
            n_o_value = f_drop ? '0 : TAIL_BITS'(r_key);
            n_o_pos   = f_drop ? '0 : r_pos;
            n_o_ovf   = f_ovf;
            n_o_eor   = 1'b1;
            if (r_last) begin
                n_len = '0;
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        end

        if (ld_emit) begin
            n_ov      = 1'b1;
            n_o_len   = LEN_BITS'(r_len);
            n_o_slot  = SLOT_BITS'(r_idx);
            n_o_value = TAIL_BITS'(i_mem_rvalue);
            n_o_pos   = i_mem_rpos;
            n_o_ovf   = r_ovf;
            n_o_eor   = emit_end;
            if (emit_end) begin
                n_len = '0;
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_idx = AW'(r_idx + AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_last    <= n_last;
        r_pos     <= n_pos;
        r_o_len   <= n_o_len;
        r_o_slot  <= n_o_slot;
        r_o_value <= n_o_value;
        r_o_pos   <= n_o_pos;
        r_o_ovf   <= n_o_ovf;
        r_o_eor   <= n_o_eor;
    end

    assign o_out.valid         = r_ov;
    assign o_out.lis_length    = r_o_len;
    assign o_out.slot          = r_o_slot;
    assign o_out.tail_value    = r_o_value;
    assign o_out.tail_position = r_o_pos;
    assign o_out.overflow      = r_o_ovf;
    assign o_out.end_of_run    = r_o_eor;

endmodule

// ===== hw/rtl/longest_increasing_subsequence_unit.sv =====
// Top level of the longest increasing subsequence unit: configuration registers,
// sequencer and tails table storage. Depends on lis_pkg, lis_if, lis_tails_mem, lis_seq.
//
// The unit takes one signed value per word on i_in and keeps the patience-sorting
// tails table. For each word it returns one word on o_out with the slot written,
// the value and its sequence position, the current length and the sticky overflow
// flag. A word marked last ends the sequence; with emit_tails set the whole table
// is returned instead as a run, one word per entry, end_of_run on the final one.
// Configuration is written on i_cfg, which is always ready; the user must write it
// only while the unit is idle, the block itself does not enforce this. A word is
// accepted in the idle state only, then binary searched with one probe of the table
// memory per step (up to ceil(log2(L+1)) probes for L stored tails, seven for 64),
// then written to the table; the result is registered and appears the cycle after
// the update. A tails run reads each entry through the registered memory read port.
// A stalled receiver holds the result register and the unit waits before its next
// result; the next input word is still accepted meanwhile. Reset clears the
// sequence state and sets the registers to strict mode without a tails run; the
// table memory needs no clearing.
module longest_increasing_subsequence_unit import lis_pkg::*; #(
    parameter int MAX_TAILS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lis_in_if.sink    i_in,
    lis_out_if.source o_out,
    lis_cfg_if.sink   i_cfg
);

    localparam int AW = (MAX_TAILS > 1) ? $clog2(MAX_TAILS) : 1;

    t_lis_cfg r_cfg, n_cfg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wvalue;
    logic [POS_BITS-1:0]   mem_wpos;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rvalue;
    logic [POS_BITS-1:0]   mem_rpos;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STRICT: n_cfg.strict_increase = i_cfg.data[0];
                CFG_EMIT:   n_cfg.emit_tails      = i_cfg.data[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strict_increase <= 1'b1;
            r_cfg.emit_tails      <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lis_tails_mem #(
        .MAX_TAILS  (MAX_TAILS),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wvalue (mem_wvalue),
        .i_wpos   (mem_wpos),
        .i_raddr  (mem_raddr),
        .o_rvalue (mem_rvalue),
        .o_rpos   (mem_rpos)
    );

    lis_seq #(
        .MAX_TAILS  (MAX_TAILS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wvalue (mem_wvalue),
        .o_mem_wpos   (mem_wpos),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rvalue (mem_rvalue),
        .i_mem_rpos   (mem_rpos)
    );

endmodule

// ===== tb/longest_increasing_subsequence_unit_tb.sv =====
// Self-checking testbench of the longest increasing subsequence unit: directed and random
// sequences under both search modes and tails runs, checked word by word against a tails table.
// Depends on lis_pkg, the channel interfaces in lis_if and the unit itself.
module longest_increasing_subsequence_unit_tb import lis_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TAILS_DEPTH = 64;
    localparam int          PHASE_WORDS = 80;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef enum {PACE_TX31_RX63, PACE_TX63_RX31, PACE_FREE} t_pace;
    typedef enum {SEQ_WIDE, SEQ_NARROW, SEQ_CLIMB, SEQ_RAMP} t_seq_kind;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } t_lis_word;

    typedef struct {
        logic [LEN_BITS-1:0]  len;
        logic [SLOT_BITS-1:0] slot;
        logic [TAIL_BITS-1:0] value;
        logic [POS_BITS-1:0]  pos;
        logic                 overflow;
        logic                 end_of_run;
    } t_lis_result;

    logic i_clk;
    logic i_rst_n;

    lis_in_if #(.VALUE_BITS(32)) in_ch ();
    lis_out_if                   out_ch ();
    lis_cfg_if                   cfg_ch ();

    longest_increasing_subsequence_unit #(
        .MAX_TAILS (TAILS_DEPTH),
        .VALUE_BITS(32)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    t_lis_word          pending[$];
    t_lis_result        lis_expect[$];
    t_pace              pace_mode = PACE_TX31_RX63;
    bit                 hold_go = 1'b0;
    logic               rx_hold;
    int                 fault_count = 0;
    int unsigned        cycle_count = 0;

    logic               strict_mode = 1'b1;
    logic               emit_mode = 1'b0;
    logic signed [31:0] tails_val [TAILS_DEPTH];
    logic [31:0]        tails_pos [TAILS_DEPTH];
    int                 tails_len = 0;
    logic [31:0]        seq_index = '0;
    logic               seq_overflow = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fault_count++;
    endtask

    task automatic add_tail_word(input int slot, input logic [31:0] value,
                                 input logic [31:0] pos, input logic eor);
        t_lis_result r;
        r.len        = LEN_BITS'(tails_len);
        r.slot       = SLOT_BITS'(slot);
        r.value      = value;
        r.pos        = pos;
        r.overflow   = seq_overflow;
        r.end_of_run = eor;
        lis_expect.insert(lis_expect.size(), r);
    endtask

    // Patience-sorting step: find the first tail that stops the value, replace it or append.
    task automatic lis_advance(input logic signed [31:0] value, input logic last);
        logic [31:0] here;
        int          hit;
        bit          dropped;
        int          k;
        here    = seq_index;
        dropped = 1'b0;
        if (seq_index != 32'hFFFF_FFFF) seq_index++;
        hit = tails_len;
        for (k = 0; k < tails_len; k++) begin
            if (strict_mode ? (tails_val[k] >= value) : (tails_val[k] > value)) begin
                hit = k;
                break;
            end
        end
        if (hit == tails_len) begin
            if (tails_len == TAILS_DEPTH) begin
                dropped      = 1'b1;
                seq_overflow = 1'b1;
            end else begin
                tails_len++;
            end
        end
        if (!dropped) begin
            tails_val[hit] = value;
            tails_pos[hit] = here;
        end
        if (last && emit_mode) begin
            for (k = 0; k < tails_len; k++)
                add_tail_word(k, tails_val[k], tails_pos[k], k == tails_len - 1);
        end else if (dropped) begin
            add_tail_word(0, '0, '0, 1'b1);
        end else begin
            add_tail_word(hit, value, here, 1'b1);
        end
        if (last) begin
            tails_len    = 0;
            seq_index    = '0;
            seq_overflow = 1'b0;
        end
    endtask

    function automatic bit sender_gap();
        case (pace_mode)
            PACE_TX31_RX63: return $urandom_range(0, 99) < 31;
            PACE_TX63_RX31: return $urandom_range(0, 99) < 63;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (pace_mode)
            PACE_TX31_RX63: return $urandom_range(0, 99) < 63;
            PACE_TX63_RX31: return $urandom_range(0, 99) < 31;
            default:        return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : driver
        t_lis_word w;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                w = pending.pop_front();
                lis_advance(w.value, w.last);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending.size() != 0 && !sender_gap()) begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= pending[0].value;
                    in_ch.last  <= pending[0].last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_lis_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (lis_expect.size() == 0) begin
                    flag_mismatch("unexpected word", out_ch.tail_value, '0);
                end else begin
                    want = lis_expect.pop_front();
                    if (out_ch.lis_length !== want.len)
                        flag_mismatch("lis_length", 32'(out_ch.lis_length), 32'(want.len));
                    if (out_ch.slot !== want.slot)
                        flag_mismatch("slot", 32'(out_ch.slot), 32'(want.slot));
                    if (out_ch.tail_value !== want.value)
                        flag_mismatch("tail_value", out_ch.tail_value, want.value);
                    if (out_ch.tail_position !== want.pos)
                        flag_mismatch("tail_position", out_ch.tail_position, want.pos);
                    if (out_ch.overflow !== want.overflow)
                        flag_mismatch("overflow", 32'(out_ch.overflow), 32'(want.overflow));
                    if (out_ch.end_of_run !== want.end_of_run)
                        flag_mismatch("end_of_run", 32'(out_ch.end_of_run),
                                      32'(want.end_of_run));
                end
            end
            out_ch.ready <= !rx_hold && !receiver_stall();
        end
    end

    // The receiver holds off for a long stretch so that the unit backs up onto its input.
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_word(input logic signed [31:0] value, input logic last);
        t_lis_word w;
        w.value = value;
        w.last  = last;
        pending.insert(pending.size(), w);
    endtask

    task automatic queue_sequence(input t_seq_kind kind, input int len, input logic closes);
        logic signed [31:0] v;
        int                 k;
        v = $urandom;
        for (k = 0; k < len; k++) begin
            case (kind)
                SEQ_WIDE:   v = $urandom;
                SEQ_NARROW: v = $signed($urandom_range(0, 7)) - 4;
                SEQ_CLIMB:  v = v + $signed($urandom_range(0, 1 << 20)) - (1 << 18);
                default: begin
                    if (k == 0) v = 32'sh8000_0000 + $signed($urandom_range(0, 1000));
                    else        v = v + $signed($urandom_range(1, 1 << 24));
                end
            endcase
            queue_word(v, closes && k == len - 1);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending.size() != 0 || lis_expect.size() != 0);
    endtask

    task automatic cfg_write(input logic strict, input logic emit);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_STRICT;
        cfg_ch.data  <= strict;
        do @(posedge i_clk); while (!cfg_ch.ready);
        strict_mode = strict;
        cfg_ch.index <= CFG_EMIT;
        cfg_ch.data  <= emit;
        do @(posedge i_clk); while (!cfg_ch.ready);
        emit_mode = emit;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic strict, input logic emit, input t_pace pace,
                             input bit ramp, input bit hold, input bit closes);
        int        queued;
        int        len;
        t_seq_kind kind;
        cfg_write(strict, emit);
        pace_mode <= pace;
        if (hold) hold_go <= 1'b1;
        queued = 0;
        if (ramp) begin
            len = $urandom_range(66, 72);
            queue_sequence(SEQ_RAMP, len, 1'b1);
            queued = len;
        end
        while (queued < PHASE_WORDS) begin
            len    = $urandom_range(1, 12);
            kind   = t_seq_kind'($urandom_range(0, 2));
            queued += len;
            queue_sequence(kind, len, closes || queued < PHASE_WORDS);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_STRICT;
        cfg_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: strict search, one word per item.
        queue_word(32'sd0, 1'b0);
        queue_word(-32'sd1, 1'b0);
        queue_word(32'sh7FFF_FFFF, 1'b0);
        queue_word(32'sh8000_0000, 1'b0);
        queue_word(32'sd5, 1'b0);
        queue_word(32'sd5, 1'b0);
        queue_word(32'sd6, 1'b1);
        wait_drained();

        // Non-strict search lets equal values append; a one-item sequence gives a run of one.
        cfg_write(1'b0, 1'b1);
        queue_word(32'sd3, 1'b0);
        queue_word(32'sd3, 1'b0);
        queue_word(32'sd3, 1'b0);
        queue_word(32'sh8000_0000, 1'b0);
        queue_word(32'sh7FFF_FFFF, 1'b1);
        queue_word(32'sd7, 1'b1);
        wait_drained();

        cfg_write(1'b1, 1'b1);
        queue_word(32'sd4, 1'b0);
        queue_word(32'sd4, 1'b0);
        queue_word(-32'sd5, 1'b1);
        wait_drained();

        run_phase(1'b1, 1'b1, PACE_TX31_RX63, 1'b1, 1'b0, 1'b1);
        run_phase(1'b0, 1'b0, PACE_TX63_RX31, 1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, PACE_FREE, 1'b1, 1'b1, 1'b1);
        run_phase(1'b0, 1'b1, PACE_FREE, 1'b0, 1'b0, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && lis_expect.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
